### hw/rtl/pngunf_pkg.sv
// ----------------------------------------------------------------------------
// pngunf_pkg
// Shared types and codes for the png scanline unfilter block.
// ----------------------------------------------------------------------------
package pngunf_pkg;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // pixel formats
  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_RGBA = 2'd2;

  // png filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // result status
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_FILTER = 2'd1;
  localparam logic [1:0] STAT_PAST_END   = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // output queue
  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [1:0] {
    TOK_FILTER,
    TOK_SAMPLE,
    TOK_ERROR
  } tok_kind_t;

  // one accepted byte, decoded by the sequencer
  typedef struct packed {
    tok_kind_t  kind;
    logic [1:0] status;
    logic [2:0] filt;
    logic [7:0] data;
    logic [1:0] ch;
    logic [1:0] fmt;
    logic       above_ok;
    logic       pixel_done;
    logic       row_last;
    logic       image_last;
    logic [7:0] x;
    logic [7:0] row;
  } token_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] pixel_x;
    logic [7:0] pixel_row;
    logic       row_last;
    logic       image_last;
    logic [1:0] status;
  } out_beat_t;

endpackage

### hw/rtl/png_scanline_unfilter_to_bgra.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_to_bgra
// PNG scanline unfilter (None/Sub/Up/Average/Paeth) with BGRA pixel output.
// ----------------------------------------------------------------------------
// output path: last byte's token register, then the result queue
// throughput: one input byte per cycle while s_tready is high, set by the row
//   store reading and writing once each cycle on separate read and write ports
// reset: synchronous, clears counters, error and the result queue; the row
//   store is not cleared and holds the previous row once row 0 has passed
module png_scanline_unfilter_to_bgra #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first_of_image
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // blue, green, red, alpha, pixel_x, pixel_row
  output logic        m_tlast,   // row_last
  output logic [2:0]  m_tuser,   // [0] image_last, [2:1] status
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pngunf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * 4);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  logic [1:0]    pixel_format;
  logic [8:0]    image_width;
  logic [8:0]    image_height;
  logic          cfg_write;

  logic          accept;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          tok_valid;
  token_t        tok;
  logic [AW-1:0] tok_pos;
  logic          push;
  out_beat_t     push_beat;
  out_beat_t     head_beat;
  logic [CW-1:0] q_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGBA;
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_FORMAT: pixel_format <= pwdata[1:0];
        REG_WIDTH:  image_width  <= pwdata[8:0];
        REG_HEIGHT: image_height <= pwdata[8:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FORMAT: prdata = {30'd0, pixel_format};
      REG_WIDTH:  prdata = {23'd0, image_width};
      REG_HEIGHT: prdata = {23'd0, image_height};
      default:    prdata = 32'd0;
    endcase
  end

  // room for the beat in flight plus the one taken this cycle
  assign s_tready = (q_count + CW'(tok_valid)) <= CW'(2);
  assign accept   = s_tvalid && s_tready;

  pngunf_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data       (s_tdata),
    .first      (s_tuser),
    .fmt        (pixel_format),
    .width_cfg  (image_width),
    .height_cfg (image_height),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .tok_pos    (tok_pos)
  );

  pngunf_recon #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_recon (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pos   (tok_pos),
    .push      (push),
    .beat      (push_beat)
  );

  pngunf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .pop       (m_tready),
    .valid     (m_tvalid),
    .head_beat (head_beat),
    .count     (q_count)
  );

  assign m_tdata = {head_beat.pixel_row, head_beat.pixel_x, head_beat.alpha,
                    head_beat.red, head_beat.green, head_beat.blue};
  assign m_tlast = head_beat.row_last;
  assign m_tuser = {head_beat.status, head_beat.image_last};

endmodule

### hw/rtl/pngunf_seq.sv
// ----------------------------------------------------------------------------
// pngunf_seq
// Byte sequencer: tracks row, byte and channel position, checks filter bytes
// and the image end, and issues the row store read for each sample byte.
// ----------------------------------------------------------------------------
module pngunf_seq #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int AW = $clog2(MAX_WIDTH * 4)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data,
  input  logic                first,
  input  logic [1:0]          fmt,
  input  logic [8:0]          width_cfg,
  input  logic [8:0]          height_cfg,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output logic                tok_valid,
  output pngunf_pkg::token_t  tok,
  output logic [AW-1:0]       tok_pos
);
  import pngunf_pkg::*;

  localparam int BIW = $clog2(MAX_WIDTH * 4 + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int WCW = (WW > 9) ? WW : 9;
  localparam int HCW = (RW > 9) ? RW : 9;
  localparam int ZW  = WCW + 2;
  // divide by three as multiply by reciprocal, exact for pos < 2**AW
  localparam int S   = AW + 1;
  localparam int M   = (2 ** S + 2) / 3;

  logic [BIW-1:0] byte_index, byte_index_next;
  logic [RW-1:0]  row_index, row_index_next;
  logic [1:0]     channel_index, channel_index_next;
  logic [1:0]     error_flag, error_flag_next;
  logic [2:0]     filter_kind, filter_kind_next;
  token_t         tok_next;

  logic [2:0]     chans;
  logic [WCW-1:0] width_c;
  logic [HCW-1:0] height_c;
  logic [ZW-1:0]  row_bytes;
  logic [BIW-1:0] bi_eff;
  logic [RW-1:0]  ri_eff;
  logic [1:0]     ch_eff;
  logic [1:0]     err_eff;
  logic [AW-1:0]  pos;
  logic [AW+S-1:0] prod;
  logic [7:0]     x;
  logic           pixel_done;
  logic           row_done;
  logic           image_end;
  logic           is_sample;

  always_comb begin
    unique case (fmt)
      FMT_GRAY: chans = 3'd1;
      FMT_RGB:  chans = 3'd3;
      default:  chans = 3'd4;
    endcase

    priority if (width_cfg == 9'd0) begin
      width_c = WCW'(1);
    end else if (WCW'(width_cfg) > WCW'(MAX_WIDTH)) begin
      width_c = WCW'(MAX_WIDTH);
    end else begin
      width_c = WCW'(width_cfg);
    end

    priority if (height_cfg == 9'd0) begin
      height_c = HCW'(1);
    end else if (HCW'(height_cfg) > HCW'(MAX_HEIGHT)) begin
      height_c = HCW'(MAX_HEIGHT);
    end else begin
      height_c = HCW'(height_cfg);
    end

    unique case (fmt)
      FMT_GRAY: row_bytes = ZW'(width_c);
      FMT_RGB:  row_bytes = ZW'(width_c) + (ZW'(width_c) << 1);
      default:  row_bytes = ZW'(width_c) << 2;
    endcase

    // first beat of an image clears position and error before it is decoded
    bi_eff  = first ? '0 : byte_index;
    ri_eff  = first ? '0 : row_index;
    ch_eff  = first ? '0 : channel_index;
    err_eff = first ? STAT_OK : error_flag;

    pos  = AW'(bi_eff - BIW'(1));
    prod = (AW+S)'(pos) * (AW+S)'(M);

    unique case (fmt)
      FMT_GRAY: x = 8'(pos);
      FMT_RGB:  x = 8'(prod >> S);
      default:  x = 8'(pos >> 2);
    endcase

    pixel_done = ({1'b0, ch_eff} + 3'd1) >= chans;
    row_done   = ZW'(bi_eff) >= row_bytes;
    image_end  = ((HCW+1)'(ri_eff) + (HCW+1)'(1)) >= (HCW+1)'(height_c);
    is_sample  = (err_eff == STAT_OK) && (bi_eff != '0);
  end

  always_comb begin
    byte_index_next    = bi_eff;
    row_index_next     = ri_eff;
    channel_index_next = ch_eff;
    error_flag_next    = err_eff;
    filter_kind_next   = filter_kind;
    tok_next           = token_t'('0);
    tok_next.data      = data;
    tok_next.fmt       = fmt;

    priority if (err_eff != STAT_OK) begin
      tok_next.kind   = TOK_ERROR;
      tok_next.status = err_eff;
    end else if (bi_eff == '0) begin
      priority if (HCW'(ri_eff) >= height_c) begin
        error_flag_next = STAT_PAST_END;
        tok_next.kind   = TOK_ERROR;
        tok_next.status = STAT_PAST_END;
      end else if (data > {5'd0, FILT_PAETH}) begin
        error_flag_next = STAT_BAD_FILTER;
        tok_next.kind   = TOK_ERROR;
        tok_next.status = STAT_BAD_FILTER;
      end else begin
        filter_kind_next   = data[2:0];
        byte_index_next    = BIW'(1);
        channel_index_next = 2'd0;
        tok_next.kind      = TOK_FILTER;
      end
    end else begin
      tok_next.kind       = TOK_SAMPLE;
      tok_next.filt       = filter_kind;
      tok_next.ch         = ch_eff;
      tok_next.above_ok   = ri_eff != '0;
      tok_next.pixel_done = pixel_done;
      tok_next.row_last   = row_done;
      tok_next.image_last = row_done && image_end;
      tok_next.x          = x;
      tok_next.row        = 8'(ri_eff);
      channel_index_next  = pixel_done ? 2'd0 : ch_eff + 2'd1;
      byte_index_next     = row_done ? '0 : bi_eff + BIW'(1);
      row_index_next      = ri_eff + RW'(row_done);
    end
  end

  assign rd_en   = accept && is_sample;
  assign rd_addr = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      row_index     <= '0;
      channel_index <= '0;
      error_flag    <= STAT_OK;
      filter_kind   <= FILT_NONE;
      tok_valid     <= 1'b0;
    end else begin
      tok_valid <= accept;
      if (accept) begin
        byte_index    <= byte_index_next;
        row_index     <= row_index_next;
        channel_index <= channel_index_next;
        error_flag    <= error_flag_next;
        filter_kind   <= filter_kind_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok     <= tok_next;
      tok_pos <= pos;
    end
  end

`ifndef ASSERT_OFF
  // an error token always carries a nonzero status
  a_err_status: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.kind == TOK_ERROR |-> tok.status != STAT_OK)
    else $error("error token without status");

  // once an error is latched, a beat without first_of_image cannot read the store
  a_err_no_read: assert property (@(posedge clk) disable iff (rst)
    error_flag != STAT_OK && !first |-> !rd_en)
    else $error("row store read while in error");
`endif

endmodule

### hw/rtl/pngunf_recon.sv
// ----------------------------------------------------------------------------
// pngunf_recon
// Sample reconstruction around the row store: reads the byte above, applies
// the filter, writes the rebuilt byte back and assembles BGRA pixels.
// ----------------------------------------------------------------------------
module pngunf_recon #(
  parameter int MAX_WIDTH = 256,
  localparam int AW    = $clog2(MAX_WIDTH * 4),
  localparam int DEPTH = MAX_WIDTH * 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  tok_valid,
  input  pngunf_pkg::token_t    tok,
  input  logic [AW-1:0]         tok_pos,
  output logic                  push,
  output pngunf_pkg::out_beat_t beat
);
  import pngunf_pkg::*;

  logic [7:0]  row_store [DEPTH];
  logic [7:0]  above_q;
  logic [31:0] left_bytes, left_bytes_next;
  logic [31:0] corner_bytes, corner_bytes_next;
  logic [23:0] pixel_gather, pixel_gather_next;

  logic [7:0]  a, b, c, pred, v;
  logic [8:0]  avg_sum;
  logic        wr_en;

  function automatic logic [7:0] paeth(input logic [7:0] pa, input logic [7:0] pb,
                                       input logic [7:0] pc);
    logic signed [9:0] p, da, db, dc;
    logic [7:0] res;
    p  = $signed({2'b00, pa}) + $signed({2'b00, pb}) - $signed({2'b00, pc});
    da = p - $signed({2'b00, pa});
    db = p - $signed({2'b00, pb});
    dc = p - $signed({2'b00, pc});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    priority if (da <= db && da <= dc) begin
      res = pa;
    end else if (db <= dc) begin
      res = pb;
    end else begin
      res = pc;
    end
    return res;
  endfunction

  // read issued on the accept cycle, data lines up with the token
  always_ff @(posedge clk) begin
    if (rd_en) begin
      above_q <= row_store[rd_addr];
    end
    if (wr_en) begin
      row_store[tok_pos] <= v;
    end
  end

  always_comb begin
    a       = left_bytes[{tok.ch, 3'b000} +: 8];
    b       = tok.above_ok ? above_q : 8'd0;
    c       = tok.above_ok ? corner_bytes[{tok.ch, 3'b000} +: 8] : 8'd0;
    avg_sum = {1'b0, a} + {1'b0, b};

    unique case (tok.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    v = tok.data + pred;

    wr_en = tok_valid && tok.kind == TOK_SAMPLE;
  end

  always_comb begin
    left_bytes_next   = left_bytes;
    corner_bytes_next = corner_bytes;
    pixel_gather_next = pixel_gather;
    if (tok_valid && tok.kind == TOK_FILTER) begin
      left_bytes_next   = '0;
      corner_bytes_next = '0;
      pixel_gather_next = '0;
    end else if (wr_en) begin
      left_bytes_next[{tok.ch, 3'b000} +: 8]   = v;
      corner_bytes_next[{tok.ch, 3'b000} +: 8] = b;
      if (tok.pixel_done) begin
        pixel_gather_next = '0;
      end else begin
        unique case (tok.ch)
          2'd0:    pixel_gather_next[7:0]   = v;
          2'd1:    pixel_gather_next[15:8]  = v;
          2'd2:    pixel_gather_next[23:16] = v;
          default: pixel_gather_next        = pixel_gather;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_bytes   <= '0;
      corner_bytes <= '0;
      pixel_gather <= '0;
    end else begin
      left_bytes   <= left_bytes_next;
      corner_bytes <= corner_bytes_next;
      pixel_gather <= pixel_gather_next;
    end
  end

  always_comb begin
    beat = out_beat_t'('0);
    push = tok_valid && (tok.kind == TOK_ERROR ||
                         (tok.kind == TOK_SAMPLE && tok.pixel_done));
    if (tok.kind == TOK_ERROR) begin
      beat.status = tok.status;
    end else begin
      unique case (tok.fmt)
        FMT_GRAY: begin
          beat.blue  = v;
          beat.green = v;
          beat.red   = v;
          beat.alpha = ALPHA_OPAQUE;
        end
        FMT_RGB: begin
          beat.blue  = v;
          beat.green = pixel_gather[15:8];
          beat.red   = pixel_gather[7:0];
          beat.alpha = ALPHA_OPAQUE;
        end
        default: begin
          beat.blue  = pixel_gather[23:16];
          beat.green = pixel_gather[15:8];
          beat.red   = pixel_gather[7:0];
          beat.alpha = v;
        end
      endcase
      beat.pixel_x    = tok.x;
      beat.pixel_row  = tok.row;
      beat.row_last   = tok.row_last;
      beat.image_last = tok.image_last;
      beat.status     = STAT_OK;
    end
  end

`ifndef ASSERT_OFF
  // consecutive samples never touch the same entry, so no forwarding is needed
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en |-> rd_addr != tok_pos)
    else $error("row store read and write to the same entry");
`endif

endmodule

### hw/rtl/pngunf_outq.sv
// ----------------------------------------------------------------------------
// pngunf_outq
// Small result queue between the reconstruction stage and the output port.
// ----------------------------------------------------------------------------
module pngunf_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pngunf_pkg::out_beat_t push_beat,
  input  logic                  pop,
  output logic                  valid,
  output pngunf_pkg::out_beat_t head_beat,
  output logic [$clog2(pngunf_pkg::OUTQ_DEPTH+1)-1:0] count
);
  import pngunf_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  out_beat_t      slots [OUTQ_DEPTH];
  logic [PW-1:0]  head, tail;
  logic [CW-1:0]  count_next;
  logic           do_pop;

  assign valid     = count != '0;
  assign head_beat = slots[head];
  assign do_pop    = pop && valid;

  always_comb begin
    count_next = count + CW'(push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        tail <= tail + PW'(1);
      end
      if (do_pop) begin
        head <= head + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_beat;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !do_pop |-> count != CW'(OUTQ_DEPTH))
    else $error("output queue overflow");
`endif

endmodule
